/* hdl/bot_pkg.sv */
// ----------------------------------------------------------------------------
// bot_pkg: shared types and constants for the box overlap table
// Action codes, kind codes, side codes and the front-to-back command record.
// ----------------------------------------------------------------------------
package bot_pkg;

    localparam int unsigned DefaultDepth = 64;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_FIRST  = 3'd2;
    localparam logic [2:0] ACT_VISION = 3'd3;
    localparam logic [2:0] ACT_LAST   = 3'd4;
    localparam logic [2:0] ACT_KIND   = 3'd5;
    localparam logic [2:0] ACT_SIDE   = 3'd6;
    localparam logic [2:0] ACT_NONE   = 3'd7;

    localparam logic [2:0] KIND_IGNORE    = 3'd3;
    localparam logic [2:0] KIND_CHARACTER = 3'd4;

    localparam logic [2:0] SIDE_NONE   = 3'd0;
    localparam logic [2:0] SIDE_RIGHT  = 3'd1;
    localparam logic [2:0] SIDE_LEFT   = 3'd2;
    localparam logic [2:0] SIDE_BOTTOM = 3'd3;
    localparam logic [2:0] SIDE_TOP    = 3'd4;

    // Command handed from the front end to the execution engine
    typedef struct packed {
        logic [2:0]         action;
        logic [15:0]        self_id;
        logic signed [20:0] ax;     // test box left (moved for first hit)
        logic signed [20:0] ay;
        logic signed [19:0] box_x;  // unmoved box, for side and insert
        logic signed [19:0] box_y;
        logic [18:0]        box_w;
        logic [18:0]        box_h;
        logic [2:0]         kind;
        logic               stop_first; // stop at first hit
    } bot_cmd_t;

endpackage

/* hdl/box_overlap_table.sv */
// Box overlap table.
// Engine takes a new command only in its idle state; the front holds one more in its queue.
// A stalled result holds the engine in its output state until the output frees.
// Reset: asynchronous, active low; empties the table (entry count to zero).
// ----------------------------------------------------------------------------
// box_overlap_table: top level
// Front stage and one-entry queue feeding the table scan engine.
// ----------------------------------------------------------------------------
module box_overlap_table
    import bot_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DefaultDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [15:0]        self_id,
    input  logic signed [19:0] box_x,
    input  logic signed [19:0] box_y,
    input  logic [18:0]        box_w,
    input  logic [18:0]        box_h,
    input  logic signed [19:0] move_dx,
    input  logic signed [19:0] move_dy,
    input  logic [2:0]         kind,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [2:0]         hit_kind,
    output logic [15:0]        hit_id,
    output logic signed [19:0] hit_x,
    output logic signed [19:0] hit_y,
    output logic [18:0]        hit_w,
    output logic [18:0]        hit_h,
    output logic [2:0]         side,
    output logic               overflow
);

    logic     cmd_valid;
    logic     cmd_take;
    bot_cmd_t cmd;

    bot_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .action, .self_id, .box_x, .box_y,
        .box_w, .box_h, .move_dx, .move_dy, .kind,
        .cmd_valid, .cmd, .cmd_take
    );

    bot_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .out_valid, .out_stall,
        .hit, .hit_kind, .hit_id, .hit_x, .hit_y, .hit_w, .hit_h, .side, .overflow
    );

endmodule

/* hdl/bot_front.sv */
// ----------------------------------------------------------------------------
// bot_front: input stage
// Accepts items, forms the moved test box and decodes the stop rule.
// ----------------------------------------------------------------------------
module bot_front
    import bot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [15:0]        self_id,
    input  logic signed [19:0] box_x,
    input  logic signed [19:0] box_y,
    input  logic [18:0]        box_w,
    input  logic [18:0]        box_h,
    input  logic signed [19:0] move_dx,
    input  logic signed [19:0] move_dy,
    input  logic [2:0]         kind,
    output logic               cmd_valid,
    output bot_cmd_t           cmd,
    input  logic               cmd_take
);

    logic     full_reg;
    bot_cmd_t cmd_reg;
    bot_cmd_t cmd_next;

    assign in_stall  = full_reg;
    assign cmd_valid = full_reg;
    assign cmd       = cmd_reg;

    // Decode and pre-add the move offset
    always_comb
    begin
        cmd_next.action     = action;
        cmd_next.self_id    = self_id;
        cmd_next.box_x      = box_x;
        cmd_next.box_y      = box_y;
        cmd_next.box_w      = box_w;
        cmd_next.box_h      = box_h;
        cmd_next.kind       = kind;
        cmd_next.stop_first = (action == ACT_FIRST) || (action == ACT_VISION);
        if (action == ACT_FIRST)
        begin
            cmd_next.ax = 21'(box_x) + 21'(move_dx);
            cmd_next.ay = 21'(box_y) + 21'(move_dy);
        end
        else
        begin
            cmd_next.ax = 21'(box_x);
            cmd_next.ay = 21'(box_y);
        end
    end

    // One-entry queue to the engine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (in_valid && !full_reg)
            full_reg <= 1'b1;
        else if (cmd_take)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !full_reg)
            cmd_reg <= cmd_next;
    end

endmodule

/* hdl/bot_engine.sv */
// ----------------------------------------------------------------------------
// bot_engine: table store and scan sequencer
// Holds the box table in a memory and runs insert, remove and queries.
// ----------------------------------------------------------------------------
module bot_engine
    import bot_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DefaultDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  bot_cmd_t           cmd,
    output logic               cmd_take,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [2:0]         hit_kind,
    output logic [15:0]        hit_id,
    output logic signed [19:0] hit_x,
    output logic signed [19:0] hit_y,
    output logic [18:0]        hit_w,
    output logic [18:0]        hit_h,
    output logic [2:0]         side,
    output logic               overflow
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = 16 + 3 + 20 + 20 + 19 + 19;

    typedef struct packed {
        logic [15:0]        id;
        logic [2:0]         kind;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [18:0]        w;
        logic [18:0]        h;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_SCAN, ST_SHIFT, ST_SHIFT_WR, ST_DONE, ST_OUT
    } state_t;

    logic [EW-1:0] mem [TABLE_DEPTH];
    entry_t        rd_data;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    state_t        state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;      // index of entry in rd_data
    logic [15:0]   last_id_reg;
    logic [15:0]   prev_id_reg;  // id of the entry scanned before idx
    bot_cmd_t      cmd_reg;
    logic          found_reg;
    entry_t        best_reg;

    // working result, copied to the output registers when they are free
    logic          hit_reg;
    entry_t        res_reg;
    logic [2:0]    side_reg;
    logic          ovf_reg;

    logic          out_valid_reg;
    logic          out_hit_reg;
    entry_t        out_res_reg;
    logic [2:0]    out_side_reg;
    logic          out_ovf_reg;

    logic          ins_ok;

    // Insert accepted with room left in the table
    assign ins_ok = (cmd.action == ACT_INSERT) && (count_reg < CW'(TABLE_DEPTH));

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    // Eligibility and strict overlap of the current entry
    logic eligible, overlap, match;
    logic signed [21:0] a_r, a_b, b_r, b_b;
    always_comb
    begin
        unique case (cmd_reg.action)
            ACT_VISION: eligible = (rd_data.kind == KIND_CHARACTER);
            ACT_KIND:   eligible = (rd_data.kind == cmd_reg.kind);
            default:    eligible = (rd_data.kind != KIND_IGNORE);
        endcase
        a_r = 22'(cmd_reg.ax) + 22'($signed({1'b0, cmd_reg.box_w}));
        a_b = 22'(cmd_reg.ay) + 22'($signed({1'b0, cmd_reg.box_h}));
        b_r = 22'(rd_data.x) + 22'($signed({1'b0, rd_data.w}));
        b_b = 22'(rd_data.y) + 22'($signed({1'b0, rd_data.h}));
        overlap = (a_r > 22'(rd_data.x)) && (22'(cmd_reg.ax) < b_r)
               && (a_b > 22'(rd_data.y)) && (22'(cmd_reg.ay) < b_b);
        match = (rd_data.id != cmd_reg.self_id) && eligible && overlap;
    end

    // Side of the last hit against the unmoved box
    logic [2:0] side_calc;
    logic signed [20:0] bx_r, by_b;
    always_comb
    begin
        bx_r = 21'(cmd_reg.box_x) + 21'($signed({1'b0, cmd_reg.box_w}));
        by_b = 21'(cmd_reg.box_y) + 21'($signed({1'b0, cmd_reg.box_h}));
        if (bx_r > 21'(best_reg.x) && best_reg.x > cmd_reg.box_x)
            side_calc = SIDE_RIGHT;
        else if (best_reg.x < cmd_reg.box_x)
            side_calc = SIDE_LEFT;
        else if (by_b > 21'(best_reg.y) && best_reg.y > cmd_reg.box_y)
            side_calc = SIDE_BOTTOM;
        else if (best_reg.y < cmd_reg.box_y)
            side_calc = SIDE_TOP;
        else
            side_calc = SIDE_NONE;
    end

    // Memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data;
        rd_addr = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = '0;
                if (cmd_valid && ins_ok)
                begin
                    wr_en   = 1'b1;
                    wr_addr = count_reg[AW-1:0];
                    wr_data.id   = (count_reg != '0) ? last_id_reg + 16'd1 : 16'd1;
                    wr_data.kind = cmd.kind;
                    wr_data.x    = cmd.box_x;
                    wr_data.y    = cmd.box_y;
                    wr_data.w    = cmd.box_w;
                    wr_data.h    = cmd.box_h;
                end
            end
            ST_READ:  rd_addr = idx_reg[AW-1:0];
            ST_SCAN:  rd_addr = AW'(idx_reg + CW'(1));
            ST_SHIFT: rd_addr = AW'(idx_reg + CW'(1));
            ST_SHIFT_WR:
            begin
                // rd_data holds entry idx+1; move it down one
                wr_en   = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                rd_addr = AW'(idx_reg + CW'(2));
            end
            default: ;
        endcase
    end

    assign cmd_take  = (state_reg == ST_IDLE) && cmd_valid;
    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign hit_kind  = out_res_reg.kind;
    assign hit_id    = out_res_reg.id;
    assign hit_x     = out_res_reg.x;
    assign hit_y     = out_res_reg.y;
    assign hit_w     = out_res_reg.w;
    assign hit_h     = out_res_reg.h;
    assign side      = out_side_reg;
    assign overflow  = out_ovf_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            // output register: loaded from ST_OUT, emptied by a transfer
            if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        best_reg  <= '0;
                        hit_reg   <= ins_ok;
                        res_reg   <= ins_ok ? wr_data : '0;
                        side_reg  <= SIDE_NONE;
                        ovf_reg   <= (cmd.action == ACT_INSERT) && !ins_ok;
                        if (cmd.action == ACT_INSERT)
                        begin
                            if (ins_ok)
                            begin
                                last_id_reg <= wr_data.id;
                                count_reg   <= count_reg + CW'(1);
                            end
                            state_reg <= ST_OUT;
                        end
                        else if (cmd.action == ACT_NONE || count_reg == '0)
                            state_reg <= ST_OUT;
                        else
                            state_reg <= ST_READ;
                    end
                end
                ST_READ:
                    state_reg <= ST_SCAN;
                ST_SCAN:
                begin
                    if (cmd_reg.action == ACT_REMOVE)
                    begin
                        if (rd_data.id == cmd_reg.self_id)
                        begin
                            found_reg <= 1'b1;
                            best_reg  <= rd_data;
                            // tail removed: the entry before it becomes the last
                            if (idx_reg + CW'(1) >= count_reg)
                            begin
                                last_id_reg <= prev_id_reg;
                                state_reg   <= ST_DONE;
                            end
                            else
                                state_reg <= ST_SHIFT;
                        end
                        else if (idx_reg + CW'(1) >= count_reg)
                            state_reg <= ST_DONE;
                        else
                        begin
                            prev_id_reg <= rd_data.id;
                            idx_reg     <= idx_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (match)
                        begin
                            found_reg <= 1'b1;
                            best_reg  <= rd_data;
                        end
                        if ((match && cmd_reg.stop_first) || idx_reg + CW'(1) >= count_reg)
                            state_reg <= ST_DONE;
                        else
                            idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_SHIFT:
                    // read of idx+1 in flight
                    state_reg <= ST_SHIFT_WR;
                ST_SHIFT_WR:
                begin
                    if (idx_reg + CW'(2) >= count_reg)
                        state_reg <= ST_DONE;
                    idx_reg <= idx_reg + CW'(1);
                end
                ST_DONE:
                begin
                    hit_reg <= found_reg;
                    res_reg <= found_reg ? best_reg : '0;
                    if (cmd_reg.action == ACT_SIDE && found_reg)
                        side_reg <= side_calc;
                    if (cmd_reg.action == ACT_REMOVE && found_reg)
                        count_reg <= count_reg - CW'(1);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_hit_reg  <= hit_reg;
                        out_res_reg  <= res_reg;
                        out_side_reg <= side_reg;
                        out_ovf_reg  <= ovf_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* sim/box_overlap_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_overlap_checker: prediction and comparison for the box overlap table
// Watches both channels, keeps its own copy of the box table, works out the
// result of each accepted command and compares it with the transfer out.
// ----------------------------------------------------------------------------
module box_overlap_checker
    import bot_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         action,
    input  logic [15:0]        self_id,
    input  logic signed [19:0] box_x,
    input  logic signed [19:0] box_y,
    input  logic [18:0]        box_w,
    input  logic [18:0]        box_h,
    input  logic signed [19:0] move_dx,
    input  logic signed [19:0] move_dy,
    input  logic [2:0]         kind,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               hit,
    input  logic [2:0]         hit_kind,
    input  logic [15:0]        hit_id,
    input  logic signed [19:0] hit_x,
    input  logic signed [19:0] hit_y,
    input  logic [18:0]        hit_w,
    input  logic [18:0]        hit_h,
    input  logic [2:0]         side,
    input  logic               overflow,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count,
    output int                 count_now
);

    typedef struct {
        logic [15:0]        id;
        logic [2:0]         kind;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [18:0]        w;
        logic [18:0]        h;
    } box_t;

    typedef struct {
        logic               hit;
        logic [2:0]         kind;
        logic [15:0]        id;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [18:0]        w;
        logic [18:0]        h;
        logic [2:0]         side;
        logic               overflow;
    } answer_t;

    box_t    boxes[$];
    answer_t answers[$];

    assign pending   = answers.size();
    assign count_now = boxes.size();

    // strict overlap, all sums exact at 22 bits
    function automatic bit touches(longint ax, longint ay, longint aw, longint ah, box_t b);
        longint bx, by, bw, bh;
        bx = longint'(b.x); by = longint'(b.y); bw = longint'(b.w); bh = longint'(b.h);
        return (ax + aw > bx) && (ax < bx + bw) && (ay + ah > by) && (ay < by + bh);
    endfunction

    function automatic answer_t from_box(box_t b);
        answer_t a;
        a = '{default: 0};
        a.hit = 1'b1; a.kind = b.kind; a.id = b.id;
        a.x = b.x; a.y = b.y; a.w = b.w; a.h = b.h;
        return a;
    endfunction

    // apply one command to the table copy and return its result
    function automatic answer_t table_update(logic [2:0] act, logic [15:0] sid,
            logic signed [19:0] bx, logic signed [19:0] by, logic [18:0] bw,
            logic [18:0] bh, logic signed [19:0] dx, logic signed [19:0] dy,
            logic [2:0] knd);
        answer_t a;
        box_t    e;
        int      found;
        bit      ok;
        longint  ax, ay, lbx, lby, lbw, lbh, ox, oy;
        a = '{default: 0};
        found = -1;
        lbx = longint'(bx); lby = longint'(by); lbw = longint'(bw); lbh = longint'(bh);
        case (act)
            ACT_INSERT:
            begin
                if (boxes.size() >= DEPTH)
                    a.overflow = 1'b1;
                else
                begin
                    e.id = (boxes.size() > 0) ? boxes[$].id + 16'd1 : 16'd1;
                    e.kind = knd; e.x = bx; e.y = by; e.w = bw; e.h = bh;
                    boxes.insert(boxes.size(), e);
                    a = from_box(e);
                end
            end
            ACT_REMOVE:
            begin
                foreach (boxes[i])
                    if (found < 0 && boxes[i].id == sid)
                        found = i;
                if (found >= 0)
                begin
                    a = from_box(boxes[found]);
                    boxes.delete(found);
                end
            end
            ACT_NONE: ;
            default:
            begin
                ax = lbx; ay = lby;
                if (act == ACT_FIRST)
                begin
                    ax = lbx + longint'(dx);
                    ay = lby + longint'(dy);
                end
                foreach (boxes[i])
                begin
                    if (boxes[i].id == sid)
                        continue;
                    if (act == ACT_VISION)
                        ok = boxes[i].kind == KIND_CHARACTER;
                    else if (act == ACT_KIND)
                        ok = boxes[i].kind == knd;
                    else
                        ok = boxes[i].kind != KIND_IGNORE;
                    if (ok && touches(ax, ay, lbw, lbh, boxes[i]))
                    begin
                        if (!((act == ACT_FIRST || act == ACT_VISION) && found >= 0))
                            found = i;
                    end
                end
                if (found >= 0)
                begin
                    a = from_box(boxes[found]);
                    if (act == ACT_SIDE)
                    begin
                        ox = longint'(boxes[found].x); oy = longint'(boxes[found].y);
                        if (lbx + lbw > ox && ox > lbx)      a.side = SIDE_RIGHT;
                        else if (ox < lbx)                   a.side = SIDE_LEFT;
                        else if (lby + lbh > oy && oy > lby) a.side = SIDE_BOTTOM;
                        else if (oy < lby)                   a.side = SIDE_TOP;
                        else                                 a.side = SIDE_NONE;
                    end
                end
            end
        endcase
        return a;
    endfunction

    // watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            boxes.delete();
            answers.delete();
            fail_count <= 0;
            result_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_count <= result_count + 1;
                if (answers.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = answers.pop_front();
                    if ({hit, hit_kind, hit_id, hit_x, hit_y, hit_w, hit_h, side, overflow} !==
                        {want.hit, want.kind, want.id, want.x, want.y, want.w, want.h,
                         want.side, want.overflow})
                    begin
                        fail_count <= fail_count + 1;
                        if (hit !== want.hit)
                            $error("hit: expected %0d, got %0d", want.hit, hit);
                        if (hit_kind !== want.kind)
                            $error("hit_kind: expected %0d, got %0d", want.kind, hit_kind);
                        if (hit_id !== want.id)
                            $error("hit_id: expected %0d, got %0d", want.id, hit_id);
                        if (hit_x !== want.x)
                            $error("hit_x: expected %0d, got %0d", want.x, hit_x);
                        if (hit_y !== want.y)
                            $error("hit_y: expected %0d, got %0d", want.y, hit_y);
                        if (hit_w !== want.w)
                            $error("hit_w: expected %0d, got %0d", want.w, hit_w);
                        if (hit_h !== want.h)
                            $error("hit_h: expected %0d, got %0d", want.h, hit_h);
                        if (side !== want.side)
                            $error("side: expected %0d, got %0d", want.side, side);
                        if (overflow !== want.overflow)
                            $error("overflow: expected %0d, got %0d", want.overflow, overflow);
                    end
                end
            end
            if (in_valid && !in_stall)
                answers.insert(answers.size(),
                               table_update(action, self_id, box_x, box_y, box_w, box_h,
                                            move_dx, move_dy, kind));
        end
    end

endmodule

/* sim/tb_box_overlap_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_overlap_table: testbench for the box overlap table
// Directed corner commands, then random clustered boxes and queries with
// random gaps and stalls on both sides; a checker compares every result.
// ----------------------------------------------------------------------------
module tb_box_overlap_table;
    import bot_pkg::*;

    localparam int DEPTH = 64;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         action;
    logic [15:0]        self_id;
    logic signed [19:0] box_x;
    logic signed [19:0] box_y;
    logic [18:0]        box_w;
    logic [18:0]        box_h;
    logic signed [19:0] move_dx;
    logic signed [19:0] move_dy;
    logic [2:0]         kind;
    logic               out_valid;
    logic               out_stall;
    logic               hit;
    logic [2:0]         hit_kind;
    logic [15:0]        hit_id;
    logic signed [19:0] hit_x;
    logic signed [19:0] hit_y;
    logic [18:0]        hit_w;
    logic [18:0]        hit_h;
    logic [2:0]         side;
    logic               overflow;

    int  fail_count;
    int  pending;
    int  result_count;
    int  count_now;
    bit  hold_off;
    bit  feeding_done;
    int  sent;

    box_overlap_table #(.TABLE_DEPTH(DEPTH)) uut (.*);

    box_overlap_checker #(.DEPTH(DEPTH)) checker_i (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // random gap length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // one command transfer, then an optional idle gap
    task automatic send(logic [2:0] act, logic [15:0] sid, logic signed [19:0] bx,
                        logic signed [19:0] by, logic [18:0] bw, logic [18:0] bh,
                        logic signed [19:0] dx, logic signed [19:0] dy,
                        logic [2:0] knd, bit with_gap);
        int g;
        action <= act; self_id <= sid; box_x <= bx; box_y <= by;
        box_w <= bw; box_h <= bh; move_dx <= dx; move_dy <= dy; kind <= knd;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sent++;
        g = with_gap ? gap_len() : 0;
        @(negedge clk);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    // receiver stalls: random, with one long hold-off
    initial
    begin
        int g;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            out_stall <= (g > 0);
            if (g > 1)
                repeat (g - 1) @(negedge clk);
        end
    end

    // stimulus
    initial
    begin
        logic [2:0]         act;
        logic [15:0]        sid;
        logic signed [19:0] bx, by, dx, dy;
        logic [18:0]        bw, bh;
        int                 r;
        sent = 0;
        hold_off = 1'b0;
        feeding_done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_NONE; self_id = '0; box_x = '0; box_y = '0; box_w = '0; box_h = '0;
        move_dx = '0; move_dy = '0; kind = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, every action, special cases
        send(ACT_REMOVE, 16'd1, '0, '0, '0, '0, '0, '0, '0, 1'b1);         // empty remove
        send(ACT_FIRST, '0, '0, '0, 19'd16, 19'd16, '0, '0, '0, 1'b1);     // empty query
        send(ACT_INSERT, '0, 20'sh80000, 20'sh80000, 19'h7FFFF, 19'h7FFFF,
             '0, '0, 3'd1, 1'b1);
        send(ACT_INSERT, '0, 20'sd524287, 20'sd524287, 19'h7FFFF, 19'h7FFFF, '0, '0, 3'd7,
             1'b1);
        send(ACT_INSERT, '0, 20'sd100, 20'sd100, 19'd64, 19'd64, '0, '0, KIND_IGNORE, 1'b1);
        send(ACT_INSERT, '0, 20'sd120, 20'sd90, 19'd64, 19'd64, '0, '0, KIND_CHARACTER,
             1'b1);
        send(ACT_INSERT, '0, 20'sd80, 20'sd80, 19'd0, 19'd50, '0, '0, 3'd2, 1'b1); // zero width
        send(ACT_FIRST, 16'd0, 20'sd0, 20'sd0, 19'd40, 19'd40, 20'sd100, 20'sd100, '0, 1'b1);
        send(ACT_FIRST, 16'd0, 20'sd524287, 20'sd524287, 19'h7FFFF, 19'h7FFFF,
             20'sd524287, 20'sd524287, '0, 1'b1);
        send(ACT_FIRST, 16'd0, 20'sh80000, 20'sh80000, 19'h7FFFF, 19'h7FFFF,
             20'sh80000, 20'sh80000, '0, 1'b1);
        send(ACT_VISION, 16'd0, 20'sd100, 20'sd100, 19'd40, 19'd40, '0, '0, '0, 1'b1);
        send(ACT_VISION, 16'd4, 20'sd100, 20'sd100, 19'd40, 19'd40, '0, '0, '0, 1'b1); // self
        send(ACT_LAST, 16'd0, 20'sd100, 20'sd100, 19'd40, 19'd40, '0, '0, '0, 1'b1);
        send(ACT_KIND, 16'd0, 20'sd100, 20'sd100, 19'd40, 19'd40, '0, '0, KIND_IGNORE, 1'b1);
        send(ACT_SIDE, 16'd0, 20'sd100, 20'sd100, 19'd40, 19'd40, '0, '0, '0, 1'b1);
        send(ACT_SIDE, 16'd0, 20'sd130, 20'sd80, 19'd40, 19'd40, '0, '0, '0, 1'b1);
        send(ACT_SIDE, 16'd0, 20'sd120, 20'sd70, 19'd40, 19'd40, '0, '0, '0, 1'b1);
        send(ACT_SIDE, 16'd0, 20'sd120, 20'sd100, 19'd40, 19'd40, '0, '0, '0, 1'b1);
        send(ACT_NONE, 16'hFFFF, 20'sd5, 20'sd5, 19'd5, 19'd5, 20'sd1, 20'sd1, 3'd7, 1'b1);
        send(ACT_REMOVE, 16'd3, '0, '0, '0, '0, '0, '0, '0, 1'b1);
        send(ACT_REMOVE, 16'd3, '0, '0, '0, '0, '0, '0, '0, 1'b1);         // gone already
        // table is left with ids 2, 4 and 5; random fill then drives ids up
        send(ACT_REMOVE, 16'd1, '0, '0, '0, '0, '0, '0, '0, 1'b1);

        // random: clustered boxes so overlaps are common; full-table phases
        while (sent < 870)
        begin
            r = $urandom_range(0, 99);
            if (sent == 300)
                hold_off = 1'b1;
            if (r < 30 || (sent > 500 && sent < 600 && r < 75))
                act = ACT_INSERT;
            else if (r < 42)
                act = ACT_REMOVE;
            else if (r < 44)
                act = ACT_NONE;
            else
                act = 3'($urandom_range(ACT_FIRST, ACT_SIDE));
            if ($urandom_range(0, 19) == 0)
            begin
                bx = 20'($urandom); by = 20'($urandom); dx = 20'($urandom); dy = 20'($urandom);
                bw = 19'($urandom); bh = 19'($urandom);
            end
            else
            begin
                bx = 20'(int'($urandom_range(0, 800)) - 400);
                by = 20'(int'($urandom_range(0, 800)) - 400);
                dx = 20'(int'($urandom_range(0, 200)) - 100);
                dy = 20'(int'($urandom_range(0, 200)) - 100);
                bw = 19'($urandom_range(0, 300)); bh = 19'($urandom_range(0, 300));
            end
            sid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 90));
            send(act, sid, bx, by, bw, bh, dx, dy, 3'($urandom_range(0, 7)),
                 $urandom_range(0, 3) != 0);
        end
        in_valid <= 1'b0;
        feeding_done = 1'b1;
    end

    // end of run
    initial
    begin
        wait (feeding_done);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d commands, checked %0d results; table held %0d boxes at the end.",
                 sent, result_count, count_now);
        if (fail_count == 0 && pending == 0)
            $display("tb_box_overlap_table: PASS");
        else
            $display("tb_box_overlap_table: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #(12ns * 1000000);
        $display("tb_box_overlap_table: FAIL");
        $finish;
    end

endmodule
